### src/sample_bank_header_checker_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sample bank header checker
// Concurrent checks, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef SAMPLE_BANK_HEADER_CHECKER_UNIT_ASSERT_SVH
`define SAMPLE_BANK_HEADER_CHECKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SBHC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SBHC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SBHC_ASSERT(lbl, clk, rstn, prop, msg)
`define SBHC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

### src/sbhc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbhc_pkg
// Types and constants of the sample bank header checker.
// ---------------------------------------------------------------------------
package sbhc_pkg;

  localparam int unsigned POS_W       = 33;
  localparam int unsigned MIN_SIZE    = 'h14C;
  localparam int unsigned HDR_BYTES   = 'h30;   // class byte offset, header size
  localparam int unsigned CLASS_BANK  = 'h11;
  localparam int unsigned EXT_TAIL    = 36;
  localparam int unsigned MAX_MEMBERS = 127;
  localparam int unsigned NATIVE_PSZ  = 188;
  localparam int unsigned EXT_PSZ     = 224;
  localparam int unsigned COUNT_OFS   = 'h144;

  localparam logic [127:0] SIG_TEXT = "FSFSDEV3SPLXSBAC";

  typedef enum logic [2:0] {
    ST_VALID     = 3'd0,
    ST_SIGNATURE = 3'd1,
    ST_CLASS     = 3'd2,
    ST_REVISION  = 3'd3,
    ST_LENGTH    = 3'd4,
    ST_COUNT     = 3'd5
  } sbhc_status_e;

  typedef enum logic [1:0] {
    LAYOUT_NONE     = 2'd0,
    LAYOUT_NATIVE   = 2'd1,
    LAYOUT_EXTENDED = 2'd2
  } sbhc_layout_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } sbhc_in_t;

  typedef struct packed {
    sbhc_status_e status;
    logic [31:0]  revision;
    logic [31:0]  older_body_length;
    logic [31:0]  later_body_length;
    logic [7:0]   parameter_size;
    sbhc_layout_e layout_kind;
  } sbhc_out_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [3:0] rev_idx;
    rev_idx = 4'd15 - idx;
    return SIG_TEXT[{rev_idx, 3'b000} +: 8];
  endfunction

  // residue of r + b mod 5; 256 and 16 are both 1 mod 5
  function automatic logic [2:0] mod5_add(input logic [2:0] r, input logic [7:0] b);
    logic [5:0] v;
    v = 6'(r) + 6'(b[7:4]) + 6'(b[3:0]);
    if (v >= 6'd20) v = v - 6'd20;
    if (v >= 6'd10) v = v - 6'd10;
    if (v >= 6'd5)  v = v - 6'd5;
    return v[2:0];
  endfunction

endpackage

### src/sample_bank_header_checker_unit.sv
`timescale 1ns / 1ps
// The last byte sets the pending flag; the result is then loaded into the output register once it is free.
// One byte per cycle while the input is not stalled; the header state updates at each accepted byte.
// A finished result waits in a single output register; input stalls only while a
// second result is ready and that register is still held by the sink.
// Reset clears the header state (the signature flag is set), the pending flag and the output valid.
// ---------------------------------------------------------------------------
// sample_bank_header_checker_unit
// Streams a stored object byte by byte, captures the header fields and
// checks signature, class, revision, lengths and member count.
// ---------------------------------------------------------------------------
`include "sample_bank_header_checker_unit_assert.svh"

module sample_bank_header_checker_unit
  import sbhc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sbhc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sbhc_out_t out_data_o
);

  localparam logic [POS_W-1:0] POS_ALL_ONES = '1;

  // header capture state
  logic [POS_W-1:0] pos_q, pos_d;
  logic             sig_ok_q, sig_ok_d;
  logic [7:0]       class_q, class_d;
  logic [31:0]      rev_q, rev_d;
  logic [31:0]      older_q, older_d;
  logic [31:0]      later_q, later_d;
  logic [2:0]       older_m5_q, older_m5_d;
  logic [2:0]       later_m5_q, later_m5_d;
  logic [7:0]       count_q, count_d;

  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  sbhc_out_t        out_q, out_d;

  logic             in_accept;
  logic             out_load;
  logic [POS_W-1:0] p;

  assign out_load   = pend_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = pend_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // ---------------- byte capture ----------------
  always_comb begin
    pos_d      = pos_q;
    sig_ok_d   = sig_ok_q;
    class_d    = class_q;
    rev_d      = rev_q;
    older_d    = older_q;
    later_d    = later_q;
    older_m5_d = older_m5_q;
    later_m5_d = later_m5_q;
    count_d    = count_q;
    p          = pos_q;
    if (in_accept) begin
      if (in_data_i.first_byte) begin
        pos_d      = '0;
        sig_ok_d   = 1'b1;
        class_d    = '0;
        rev_d      = '0;
        older_d    = '0;
        later_d    = '0;
        older_m5_d = '0;
        later_m5_d = '0;
        count_d    = '0;
        p          = '0;
      end
      if (p[POS_W-1:4] == '0) begin
        if (sig_byte(p[3:0]) != in_data_i.data_byte) sig_ok_d = 1'b0;
      end else if (p[POS_W-1:2] == (POS_W-2)'(5)) begin
        rev_d = {rev_d[23:0], in_data_i.data_byte};
      end else if (p[POS_W-1:2] == (POS_W-2)'(6)) begin
        older_d    = {older_d[23:0], in_data_i.data_byte};
        older_m5_d = mod5_add(older_m5_d, in_data_i.data_byte);
      end else if (p[POS_W-1:2] == (POS_W-2)'(7)) begin
        later_d    = {later_d[23:0], in_data_i.data_byte};
        later_m5_d = mod5_add(later_m5_d, in_data_i.data_byte);
      end else if (p == POS_W'(HDR_BYTES)) begin
        class_d = in_data_i.data_byte;
      end else if (p == POS_W'(COUNT_OFS)) begin
        count_d = in_data_i.data_byte;
      end
      pos_d = (p != POS_ALL_ONES) ? p + POS_W'(1) : p;
    end
  end

  // ---------------- header checks ----------------
  logic             native;
  logic [31:0]      body;
  logic [POS_W-1:0] tail, logical, low_bound, rows, need_rows;
  logic             rows_mod20;

  always_comb begin
    native     = (rev_q == 32'd2);
    body       = native ? older_q : later_q;
    tail       = native ? '0 : POS_W'(EXT_TAIL);
    logical    = {1'b0, body} + POS_W'(HDR_BYTES);
    low_bound  = POS_W'(MIN_SIZE) + tail;
    rows       = logical - tail - POS_W'(MIN_SIZE);
    need_rows  = POS_W'({count_q, 4'b0000}) + POS_W'({count_q, 2'b00});
    // rows is body minus 0x11C (native) or 0x140 (extended), both 0 mod 4
    rows_mod20 = (body[1:0] == 2'b00) &&
                 (native ? (older_m5_q == 3'd4) : (later_m5_q == 3'd0));

    out_d                   = out_q;
    out_d.status            = ST_VALID;
    out_d.revision          = rev_q;
    out_d.older_body_length = older_q;
    out_d.later_body_length = later_q;
    out_d.parameter_size    = '0;
    out_d.layout_kind       = LAYOUT_NONE;
    if (pos_q < POS_W'(MIN_SIZE) || !sig_ok_q) begin
      out_d.status = ST_SIGNATURE;
    end else if (class_q != 8'(CLASS_BANK)) begin
      out_d.status = ST_CLASS;
    end else if (rev_q != 32'd2 && rev_q != 32'd4) begin
      out_d.status = ST_REVISION;
    end else if ((!native && ({1'b0, older_q} + POS_W'(EXT_TAIL)) != {1'b0, later_q}) ||
                 logical < low_bound || logical > pos_q) begin
      out_d.status = ST_LENGTH;
    end else if (!rows_mod20 || count_q > 8'(MAX_MEMBERS) || rows < need_rows) begin
      out_d.status = ST_COUNT;
    end else begin
      out_d.parameter_size = native ? 8'(NATIVE_PSZ) : 8'(EXT_PSZ);
      out_d.layout_kind    = native ? LAYOUT_NATIVE : LAYOUT_EXTENDED;
    end
    // words only shown once the class check is passed
    if (out_d.status == ST_SIGNATURE || out_d.status == ST_CLASS) begin
      out_d.revision          = '0;
      out_d.older_body_length = '0;
      out_d.later_body_length = '0;
    end
  end

  // ---------------- handshake control ----------------
  always_comb begin
    pend_d = pend_q;
    if (out_load) pend_d = 1'b0;
    if (in_accept && in_data_i.last_byte) pend_d = 1'b1;
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sig_ok_q    <= 1'b1;
      class_q     <= '0;
      rev_q       <= '0;
      older_q     <= '0;
      later_q     <= '0;
      older_m5_q  <= '0;
      later_m5_q  <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sig_ok_q    <= sig_ok_d;
      class_q     <= class_d;
      rev_q       <= rev_d;
      older_q     <= older_d;
      later_q     <= later_d;
      older_m5_q  <= older_m5_d;
      later_m5_q  <= later_m5_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  `SBHC_ASSERT(a_last_sets_pend, clk_i, rst_ni,
               in_accept && in_data_i.last_byte |=> pend_q, "last byte did not post a result")
  `SBHC_ASSERT(a_pend_held, clk_i, rst_ni,
               pend_q && out_valid_q && out_stall_i |=> pend_q && out_valid_q,
               "pending result dropped while output held")
  `SBHC_ASSERT(a_pos_monotonic, clk_i, rst_ni,
               in_accept && !in_data_i.first_byte |=> pos_q >= $past(pos_q),
               "byte position went backward without a first mark")
  `SBHC_ASSERT_NEVER(a_valid_layout, clk_i, rst_ni,
                     out_valid_q && (out_q.status == ST_VALID) == (out_q.layout_kind == LAYOUT_NONE),
                     "layout kind disagrees with status")
  `SBHC_ASSERT_NEVER(a_hidden_words, clk_i, rst_ni,
                     out_valid_q && out_q.status == ST_SIGNATURE && out_q.revision != '0,
                     "revision shown on a failed signature check")

endmodule
